// File: src/apts_pkg.sv
// Package: shared types, constants and codes of the aging priority task scheduler
package apts_pkg;

  localparam int unsigned NumTasksDefault = 16;
  localparam int unsigned MinPeriodReset  = 100;
  localparam int unsigned RtLevelReset    = 255;
  localparam int unsigned SelfId          = 16;

  typedef enum logic [1:0] {
    OP_ENABLE  = 2'd0,
    OP_DISABLE = 2'd1,
    OP_PERIOD  = 2'd2,
    OP_SCHED   = 2'd3
  } op_e;

  typedef enum logic {
    CFG_MIN_PERIOD = 1'b0,
    CFG_RT_LEVEL   = 1'b1
  } cfg_e;

  // controller -> datapath
  typedef struct packed {
    logic latch;      // capture input word
    logic en_scan;    // compare queue entry against target (enable/disable)
    logic en_commit;  // apply enable
    logic dis_commit; // apply disable
    logic per_commit; // apply set period
    logic ps_clear;   // reset pass accumulators
    logic ps_load;    // load task of current queue slot
    logic ps_div;     // start division
    logic ps_mul;     // multiply step
    logic ps_eval;    // evaluate task
    logic ps_final;   // commit chosen task
    logic idx_inc;    // advance queue index
    logic div_step;   // one divider iteration
    logic out_load;   // register result word
  } apts_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic op_sched;
    logic op_enable;
    logic op_disable;
    logic id_ok;
    logic idx_end;
    logic found;
    logic div_done;
  } apts_sts_t;

endpackage

// File: src/apts_datapath.sv
// Datapath: task tables, queue, shared divider and multiplier, result register
module apts_datapath #(
  parameter int unsigned NumTasks = apts_pkg::NumTasksDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  apts_pkg::apts_cmd_t cmd_i,
  output apts_pkg::apts_sts_t sts_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [19:0]         cfg_data_i,
  input  logic [1:0]          op_i,
  input  logic [4:0]          task_id_i,
  input  logic [7:0]          static_priority_i,
  input  logic                has_event_check_i,
  input  logic signed [31:0]  period_us_i,
  input  logic [31:0]         now_us_i,
  input  logic [15:0]         check_hits_i,
  output logic                accepted_o,
  output logic                selected_valid_o,
  output logic [3:0]          chosen_slot_o,
  output logic signed [31:0]  selected_delta_us_o,
  output logic [4:0]          waiting_count_o
);

  localparam int unsigned TW = (NumTasks > 1) ? $clog2(NumTasks) : 1;
  localparam int unsigned LW = $clog2(NumTasks + 1);

  logic [19:0] min_per_q;
  logic [7:0]  rt_lvl_q;

  logic [TW-1:0] qord_q [NumTasks];
  logic [LW-1:0] qlen_q;
  logic [7:0]    sprio_q [NumTasks];
  logic          evd_q   [NumTasks];
  logic [31:0]   per_q   [NumTasks];
  logic [31:0]   lrun_q  [NumTasks];
  logic [31:0]   lsig_q  [NumTasks];
  logic [15:0]   dyn_q   [NumTasks];
  logic [TW-1:0] run_q;
  logic          runv_q;

  // latched input word
  logic [1:0]  op_q;
  logic [4:0]  id_q;
  logic [7:0]  pr_q;
  logic        ev_q;
  logic signed [31:0] req_q;
  logic [31:0] now_q;
  logic [15:0] hit_q;

  logic [LW-1:0] idx_q;
  logic [TW-1:0] tgt;
  logic          id_ok;
  logic          found_q;
  logic [LW-1:0] fpos_q;   // found position / insertion point
  logic          ins_set_q;

  // pass accumulators
  logic          have_q, forced_q;
  logic [TW-1:0] sel_q;
  logic [15:0]   best_q;
  logic [4:0]    wait_q;
  logic [TW-1:0] k_q;
  logic signed [31:0] el_q;   // elapsed
  logic [31:0]   pd_q;        // period (>=1)

  // divider: magnitude restoring
  logic [31:0] dq_q, dr_q;
  logic [5:0]  dcnt_q;
  logic        dneg_q;
  logic signed [32:0] age_q;
  logic [15:0] mul_q;

  // output
  logic        acc_q, sv_q;
  logic [3:0]  st_q;
  logic [31:0] sd_q;
  logic [4:0]  wc_q;

  always_comb begin
    id_ok = 1'b0;
    tgt   = '0;
    if (id_q == 5'(apts_pkg::SelfId)) begin
      id_ok = runv_q;
      tgt   = run_q;
    end else if (32'(id_q) < NumTasks) begin
      id_ok = 1'b1;
      tgt   = TW'(id_q);
    end
  end

  logic [TW-1:0] cur;
  logic          idx_end;
  assign cur     = qord_q[idx_q[TW-1:0]];
  assign idx_end = (idx_q >= qlen_q);

  logic [31:0] min_per_eff;
  assign min_per_eff = {12'd0, min_per_q};

  logic signed [31:0] el_sig, el_run;
  assign el_run = signed'(now_q - lrun_q[cur]);
  assign el_sig = signed'(now_q - lsig_q[cur]);

  logic [32:0] rem_try;
  assign rem_try = {dr_q, dq_q[31]} - {1'b0, pd_q};

  logic ev_k, hit_k, rt_k;
  assign ev_k  = evd_q[k_q];
  assign hit_k = (32'(k_q) < 16) ? hit_q[4'(k_q)] : 1'b0;
  assign rt_k  = (sprio_q[k_q] == rt_lvl_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_per_q <= 20'(apts_pkg::MinPeriodReset);
      rt_lvl_q  <= 8'(apts_pkg::RtLevelReset);
      qlen_q    <= '0;
      run_q     <= '0;
      runv_q    <= 1'b0;
      for (int i = 0; i < NumTasks; i++) begin
        sprio_q[i] <= '0;
        evd_q[i]   <= 1'b0;
        per_q[i]   <= 32'(apts_pkg::MinPeriodReset);
        lrun_q[i]  <= '0;
        lsig_q[i]  <= '0;
        dyn_q[i]   <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (apts_pkg::cfg_e'(cfg_idx_i))
          apts_pkg::CFG_MIN_PERIOD: min_per_q <= cfg_data_i;
          apts_pkg::CFG_RT_LEVEL:   rt_lvl_q  <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (cmd_i.en_commit) begin
        sprio_q[tgt] <= pr_q;
        evd_q[tgt]   <= ev_q;
        for (int j = 1; j < NumTasks; j++) begin
          if (LW'(j) > fpos_q && LW'(j) <= qlen_q)
            qord_q[j] <= qord_q[j-1];
        end
        qord_q[fpos_q[TW-1:0]] <= tgt;
        qlen_q <= qlen_q + 1'b1;
      end
      if (cmd_i.dis_commit) begin
        for (int j = 0; j < NumTasks - 1; j++) begin
          if (LW'(j) >= fpos_q && LW'(j) + 1'b1 < qlen_q)
            qord_q[j] <= qord_q[j+1];
        end
        qlen_q <= qlen_q - 1'b1;
      end
      if (cmd_i.per_commit)
        per_q[tgt] <= ($signed(req_q) < $signed(min_per_eff)) ? min_per_eff : req_q;
      if (cmd_i.ps_eval) begin
        if (ev_k) begin
          if (dyn_q[k_q] != 16'd0) dyn_q[k_q] <= mul_q;
          else if (hit_k) begin
            lsig_q[k_q] <= now_q;
            dyn_q[k_q]  <= 16'd1 + 16'(sprio_q[k_q]);
          end
        end else if (!rt_k && age_q > 0) begin
          dyn_q[k_q] <= mul_q;
        end
      end
      if (cmd_i.ps_final) begin
        runv_q <= have_q;
        run_q  <= sel_q;
        if (have_q) begin
          lrun_q[sel_q] <= now_q;
          dyn_q[sel_q]  <= '0;
        end
      end
    end
  end

  // evaluation of a task: what its dynamic priority becomes this step
  logic [15:0] dyn_new;
  logic        ready, force_now;
  always_comb begin
    dyn_new   = dyn_q[k_q];
    ready     = 1'b0;
    force_now = 1'b0;
    if (ev_k) begin
      if (dyn_q[k_q] != 16'd0) begin
        dyn_new = mul_q;
        ready   = 1'b1;
      end else if (hit_k) begin
        dyn_new = 16'd1 + 16'(sprio_q[k_q]);
        ready   = 1'b1;
      end
    end else if (rt_k) begin
      if ($signed(el_q) > $signed({1'b0, pd_q})) begin
        force_now = 1'b1;
        ready     = 1'b1;
      end
    end else if (age_q > 0) begin
      dyn_new = mul_q;
      ready   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= op_i;
      id_q  <= task_id_i;
      pr_q  <= static_priority_i;
      ev_q  <= has_event_check_i;
      req_q <= period_us_i;
      now_q <= now_us_i;
      hit_q <= check_hits_i;
      idx_q <= '0;
      found_q   <= 1'b0;
      fpos_q    <= '0;
      ins_set_q <= 1'b0;
    end
    if (cmd_i.en_scan && !idx_end) begin
      if (cur == tgt && !found_q) begin
        found_q <= 1'b1;
        if (op_q == apts_pkg::OP_DISABLE) fpos_q <= idx_q;
      end
      if (op_q == apts_pkg::OP_ENABLE && !ins_set_q && sprio_q[cur] < pr_q) begin
        ins_set_q <= 1'b1;
        fpos_q    <= idx_q;
      end
    end
    if (cmd_i.en_scan && idx_end && op_q == apts_pkg::OP_ENABLE && !ins_set_q) begin
      fpos_q    <= qlen_q;
      ins_set_q <= 1'b1;
    end
    if (cmd_i.idx_inc) idx_q <= idx_q + 1'b1;
    if (cmd_i.ps_clear) begin
      have_q <= 1'b0; forced_q <= 1'b0; sel_q <= '0; best_q <= '0; wait_q <= '0;
    end
    if (cmd_i.ps_load) begin
      k_q  <= cur;
      el_q <= evd_q[cur] ? el_sig : el_run;
      pd_q <= (per_q[cur] == 32'd0) ? 32'd1 : per_q[cur];
    end
    if (cmd_i.ps_div) begin
      dneg_q <= el_q[31];
      dq_q   <= el_q[31] ? 32'(-el_q) : el_q;
      dr_q   <= '0;
      dcnt_q <= 6'd32;
    end
    if (cmd_i.div_step) begin
      if (!rem_try[32]) dr_q <= rem_try[31:0];
      else dr_q <= {dr_q[30:0], dq_q[31]};
      dq_q   <= {dq_q[30:0], ~rem_try[32]};
      dcnt_q <= dcnt_q - 1'b1;
    end
    if (cmd_i.ps_mul) begin
      age_q <= (dneg_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q}))
               + (ev_k ? 33'sd1 : 33'sd0);
    end
    if (cmd_i.ps_eval) begin
      if (ready && wait_q < 5'd31) wait_q <= wait_q + 1'b1;
      if (force_now) begin
        forced_q <= 1'b1; have_q <= 1'b1; sel_q <= k_q; best_q <= dyn_q[k_q];
      end else if (!forced_q && dyn_new > best_q) begin
        have_q <= 1'b1; sel_q <= k_q; best_q <= dyn_new;
      end
    end
    if (cmd_i.out_load) begin
      acc_q <= 1'b1; sv_q <= 1'b0; st_q <= '0; sd_q <= '0; wc_q <= '0;
      unique case (apts_pkg::op_e'(op_q))
        apts_pkg::OP_ENABLE:  acc_q <= id_ok && !found_q;
        apts_pkg::OP_DISABLE: acc_q <= id_ok && found_q;
        apts_pkg::OP_PERIOD:  acc_q <= 1'b1;
        apts_pkg::OP_SCHED: begin
          sv_q <= have_q;
          st_q <= have_q ? 4'(sel_q) : 4'd0;
          sd_q <= have_q ? now_q - lrun_q[sel_q] : 32'd0;
          wc_q <= wait_q;
        end
        default: ;
      endcase
    end
  end

  // multiply: low 16 bits of 1 + static * age
  always_ff @(posedge clk_i) begin
    if (cmd_i.ps_eval) mul_q <= mul_q;
    else mul_q <= 16'd1 + 16'(sprio_q[k_q] * age_q[15:0]);
  end

  assign sts_o.op_sched   = (op_q == apts_pkg::OP_SCHED);
  assign sts_o.op_enable  = (op_q == apts_pkg::OP_ENABLE);
  assign sts_o.op_disable = (op_q == apts_pkg::OP_DISABLE);
  assign sts_o.id_ok      = id_ok;
  assign sts_o.idx_end    = idx_end;
  assign sts_o.found      = found_q;
  assign sts_o.div_done   = (dcnt_q == 6'd0);

  assign accepted_o          = acc_q;
  assign selected_valid_o    = sv_q;
  assign chosen_slot_o       = st_q;
  assign selected_delta_us_o = sd_q;
  assign waiting_count_o     = wc_q;

endmodule

// File: src/apts_ctrl.sv
// Controller: sequences queue scans, schedule passes and the result handshake
module apts_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  apts_pkg::apts_sts_t sts_i,
  output apts_pkg::apts_cmd_t cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DEC   = 10'b0000000010,
    S_SCAN  = 10'b0000000100,
    S_APPLY = 10'b0000001000,
    S_LOAD  = 10'b0000010000,
    S_DSTRT = 10'b0000100000,
    S_DIV   = 10'b0001000000,
    S_MUL   = 10'b0010000000,
    S_EVAL  = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   ov_q, ov_d;
  logic   mulw_q, mulw_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = ov_q;

  always_comb begin
    state_d = state_q;
    ov_d    = ov_q && out_stall_i;
    mulw_d  = mulw_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: if (in_valid_i && !in_stall_o) begin
        cmd_o.latch = 1'b1;
        state_d = S_DEC;
      end
      S_DEC: begin
        if (sts_i.op_sched) begin
          cmd_o.ps_clear = 1'b1;
          state_d = S_LOAD;
        end else if (sts_i.op_enable || sts_i.op_disable) state_d = S_SCAN;
        else state_d = S_APPLY;
      end
      S_SCAN: begin
        cmd_o.en_scan = 1'b1;
        if (sts_i.idx_end) state_d = S_APPLY;
        else cmd_o.idx_inc = 1'b1;
      end
      S_APPLY: begin
        if (sts_i.id_ok) begin
          if (sts_i.op_enable) cmd_o.en_commit = !sts_i.found;
          else if (sts_i.op_disable) cmd_o.dis_commit = sts_i.found;
          else cmd_o.per_commit = 1'b1;
        end
        state_d = S_FIN;
      end
      S_LOAD: begin
        if (sts_i.idx_end) state_d = S_FIN;
        else begin
          cmd_o.ps_load = 1'b1;
          state_d = S_DSTRT;
        end
      end
      S_DSTRT: begin
        cmd_o.ps_div = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.ps_mul = 1'b1;
          mulw_d = 1'b0;
          state_d = S_MUL;
        end else cmd_o.div_step = 1'b1;
      end
      S_MUL: begin
        mulw_d = 1'b1;
        if (mulw_q) state_d = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.ps_eval = 1'b1;
        cmd_o.idx_inc = 1'b1;
        state_d = S_LOAD;
      end
      S_FIN: if (!ov_q || !out_stall_i) begin
        cmd_o.ps_final = sts_i.op_sched;
        cmd_o.out_load = 1'b1;
        ov_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
      mulw_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      mulw_q  <= mulw_d;
    end
  end

endmodule

// File: src/aging_priority_task_scheduler_unit.sv
// Top level: aging priority task scheduler
//  channel | direction | handshake
//  in      | input     | in_valid_i / in_stall_o
//  out     | output    | out_valid_o / out_stall_i
//  cfg     | input     | cfg_we_i, cfg_idx_i, cfg_data_i
// Enable/disable scan the queue, one entry a cycle.
// A schedule pass visits each queued task in turn: a 32-step divider,
// then multiply and update.
// A new word is taken once the previous result is registered; the output
// register holds a result while out_stall_i is high.
module aging_priority_task_scheduler_unit #(
  parameter int unsigned NumTasks = apts_pkg::NumTasksDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [19:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic [4:0]         task_id_i,
  input  logic [7:0]         static_priority_i,
  input  logic               has_event_check_i,
  input  logic signed [31:0] period_us_i,
  input  logic [31:0]        now_us_i,
  input  logic [15:0]        check_hits_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               accepted_o,
  output logic               selected_valid_o,
  output logic [3:0]         chosen_slot_o,
  output logic signed [31:0] selected_delta_us_o,
  output logic [4:0]         waiting_count_o
);

  apts_pkg::apts_cmd_t cmd;
  apts_pkg::apts_sts_t sts;

  apts_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  apts_datapath #(.NumTasks(NumTasks)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .op_i, .task_id_i, .static_priority_i, .has_event_check_i,
    .period_us_i, .now_us_i, .check_hits_i,
    .accepted_o, .selected_valid_o, .chosen_slot_o,
    .selected_delta_us_o, .waiting_count_o
  );

endmodule

// File: tb/testbench.sv
// Testbench: directed table and random ops on the aging priority task scheduler, checked by a predictor
module testbench;

  typedef struct {
    apts_pkg::op_e op;
    logic [4:0]  id;
    logic [7:0]  prio;
    logic        ev;
    logic [31:0] period;
    logic [31:0] now;
    logic [15:0] hits;
    logic        chk_acc; // typed-in expectation of accepted, when known at a glance
    logic        acc;
  } word_t;

  typedef struct {
    logic        acc;
    logic        sel_v;
    logic [3:0]  sel;
    logic [31:0] delta;
    logic [4:0]  waiting;
  } sched_res_t;

  localparam logic [4:0] SELF = 5'(apts_pkg::SelfId);

  logic clk_i, rst_ni;
  logic cfg_we_i, cfg_idx_i;
  logic [19:0] cfg_data_i;
  logic in_valid_i, in_stall_o;
  logic [1:0] op_i;
  logic [4:0] task_id_i;
  logic [7:0] static_priority_i;
  logic has_event_check_i;
  logic signed [31:0] period_us_i;
  logic [31:0] now_us_i;
  logic [15:0] check_hits_i;
  logic out_valid_o, out_stall_i;
  logic accepted_o, selected_valid_o;
  logic [3:0] chosen_slot_o;
  logic signed [31:0] selected_delta_us_o;
  logic [4:0] waiting_count_o;

  aging_priority_task_scheduler_unit DUT (.*);

  // predictor state
  logic [31:0] m_min_period;
  logic [7:0]  m_rt_level;
  logic [3:0]  q_order[16];
  int          q_len;
  logic [7:0]  t_prio[16];
  logic        t_ev[16];
  logic [31:0] t_period[16], t_last_run[16], t_last_sig[16], t_delta[16];
  logic [15:0] t_dyn[16];
  logic [3:0]  run_task;
  logic        run_valid;

  sched_res_t  expected_q[$];
  int          errors = 0, n_results = 0, n_sched = 0, n_picks = 0;
  longint      cycles = 0;
  logic [31:0] clock_us = 0;

  function automatic longint per_of(int k);
    return t_period[k] == 0 ? 1 : longint'(t_period[k]);
  endfunction

  function automatic sched_res_t schedule_predict(word_t w);
    sched_res_t r;
    int t, i, j, k, pos;
    logic found, have, forced, ready;
    longint age, el;
    logic [15:0] best;
    logic [3:0] sel;
    int waiting;
    r = '{1'b1, 1'b0, 4'd0, 32'd0, 5'd0};
    found = 1'b0;
    t = 0;
    if (w.id == SELF) begin
      found = run_valid;
      t = run_task;
    end else if (w.id < 16) begin
      found = 1'b1;
      t = w.id;
    end
    case (w.op)
      apts_pkg::OP_ENABLE: begin
        r.acc = 1'b0;
        if (found && q_len < 16) begin
          for (i = 0; i < q_len; i++) if (q_order[i] == t) found = 1'b0;
          if (found) begin
            t_prio[t] = w.prio;
            t_ev[t] = w.ev;
            pos = q_len;
            for (i = 0; i < q_len; i++)
              if (t_prio[q_order[i]] < w.prio) begin
                pos = i;
                break;
              end
            for (j = q_len; j > pos; j--) q_order[j] = q_order[j-1];
            q_order[pos] = t;
            q_len++;
            r.acc = 1'b1;
          end
        end
      end
      apts_pkg::OP_DISABLE: begin
        r.acc = 1'b0;
        if (found)
          for (i = 0; i < q_len; i++)
            if (q_order[i] == t) begin
              for (j = i; j + 1 < q_len; j++) q_order[j] = q_order[j+1];
              q_len--;
              r.acc = 1'b1;
              break;
            end
      end
      apts_pkg::OP_PERIOD: begin
        if (found)
          t_period[t] = ($signed(w.period) < $signed({1'b0, m_min_period}))
                        ? m_min_period : w.period;
      end
      default: begin
        have = 0; forced = 0; sel = 0; best = 0; waiting = 0;
        for (i = 0; i < q_len; i++) begin
          k = q_order[i];
          ready = 0;
          if (t_ev[k]) begin
            if (t_dyn[k] > 0) begin
              el = longint'($signed(w.now - t_last_sig[k]));
              age = 1 + el / per_of(k);
              t_dyn[k] = 16'(1 + longint'(t_prio[k]) * age);
              ready = 1;
            end else if (w.hits[k]) begin
              t_last_sig[k] = w.now;
              t_dyn[k] = 16'(1 + t_prio[k]);
              ready = 1;
            end
          end else if (t_prio[k] == m_rt_level) begin
            if (longint'($signed(w.now - t_last_run[k])) > per_of(k)) begin
              best = t_dyn[k]; sel = k; have = 1; forced = 1; ready = 1;
            end
          end else begin
            age = longint'($signed(w.now - t_last_run[k])) / per_of(k);
            if (age > 0) begin
              t_dyn[k] = 16'(1 + longint'(t_prio[k]) * age);
              ready = 1;
            end
          end
          if (ready && waiting < 31) waiting++;
          if (!forced && t_dyn[k] > best) begin
            best = t_dyn[k]; sel = k; have = 1;
          end
        end
        run_valid = have;
        run_task = sel;
        if (have) begin
          t_delta[sel] = w.now - t_last_run[sel];
          t_last_run[sel] = w.now;
          t_dyn[sel] = 0;
          r.sel_v = 1; r.sel = sel; r.delta = t_delta[sel];
        end
        r.waiting = waiting;
      end
    endcase
    return r;
  endfunction

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver stall pattern
  int stall_mode = 0;
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // result checker
  always @(posedge clk_i) begin
    sched_res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (accepted_o !== e.acc) begin
          $error("accepted exp %0d got %0d", e.acc, accepted_o); errors++;
        end
        if (selected_valid_o !== e.sel_v) begin
          $error("selected_valid exp %0d got %0d", e.sel_v, selected_valid_o); errors++;
        end
        if (chosen_slot_o !== e.sel) begin
          $error("chosen_slot exp %0d got %0d", e.sel, chosen_slot_o); errors++;
        end
        if (selected_delta_us_o !== e.delta) begin
          $error("selected_delta_us exp %0d got %0d", $signed(e.delta),
                 selected_delta_us_o); errors++;
        end
        if (waiting_count_o !== e.waiting) begin
          $error("waiting_count exp %0d got %0d", e.waiting, waiting_count_o); errors++;
        end
      end
    end
  end

  task automatic send_word(word_t w);
    sched_res_t r;
    op_i <= w.op; task_id_i <= w.id; static_priority_i <= w.prio;
    has_event_check_i <= w.ev; period_us_i <= w.period; now_us_i <= w.now;
    check_hits_i <= w.hits;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    r = schedule_predict(w);
    if (w.chk_acc && r.acc !== w.acc) begin
      $error("table row accepted exp %0d predictor %0d", w.acc, r.acc);
      errors++;
    end
    if (w.op == apts_pkg::OP_SCHED) n_sched++;
    if (r.sel_v) n_picks++;
    expected_q.push_back(r);
  endtask

  task automatic idle_in(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);
  endtask

  task automatic write_cfg(apts_pkg::cfg_e idx, logic [19:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == apts_pkg::CFG_MIN_PERIOD) m_min_period = 32'(val);
    else m_rt_level = val[7:0];
  endtask

  function automatic word_t mk(apts_pkg::op_e op, logic [4:0] id, logic [7:0] p,
                               logic ev, logic [31:0] per, logic [31:0] now,
                               logic [15:0] h, logic ck, logic a);
    word_t w;
    w = '{op, id, p, ev, per, now, h, ck, a};
    return w;
  endfunction

  function automatic word_t rand_word();
    word_t w;
    int r;
    r = $urandom_range(0, 99);
    w.prio = ($urandom_range(0, 5) == 0) ? m_rt_level : 8'($urandom_range(0, 255));
    w.ev = $urandom_range(0, 2) == 0;
    w.id = ($urandom_range(0, 15) == 0) ? SELF : 5'($urandom_range(0, 15));
    if ($urandom_range(0, 40) == 0) w.id = 5'($urandom_range(17, 31));
    w.period = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4000);
    clock_us += $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3000);
    w.now = clock_us;
    w.hits = 16'($urandom);
    w.chk_acc = 0; w.acc = 0;
    if (r < 45) w.op = apts_pkg::OP_SCHED;
    else if (r < 70) w.op = apts_pkg::OP_ENABLE;
    else if (r < 85) w.op = apts_pkg::OP_DISABLE;
    else w.op = apts_pkg::OP_PERIOD;
    return w;
  endfunction

  initial begin
    word_t dir[$];
    int n, i, b;
    cfg_we_i = 0; cfg_idx_i = apts_pkg::CFG_MIN_PERIOD; cfg_data_i = 0;
    in_valid_i = 0; op_i = apts_pkg::OP_ENABLE; task_id_i = 0; static_priority_i = 0;
    has_event_check_i = 0; period_us_i = 0; now_us_i = 0; check_hits_i = 0;
    rst_ni = 0;
    m_min_period = apts_pkg::MinPeriodReset; m_rt_level = 8'(apts_pkg::RtLevelReset);
    q_len = 0; run_valid = 0; run_task = 0;
    for (i = 0; i < 16; i++) begin
      q_order[i] = 0; t_prio[i] = 0; t_ev[i] = 0; t_period[i] = apts_pkg::MinPeriodReset;
      t_last_run[i] = 0; t_last_sig[i] = 0; t_dyn[i] = 0; t_delta[i] = 0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    dir.push_back(mk(apts_pkg::OP_SCHED,   0,  0, 0, 0, 0, 16'h0000, 0, 0));
    dir.push_back(mk(apts_pkg::OP_ENABLE,  SELF, 5, 0, 0, 0, 0, 1, 0)); // no running task
    dir.push_back(mk(apts_pkg::OP_PERIOD,  SELF, 0, 0, 500, 0, 0, 1, 1));
    dir.push_back(mk(apts_pkg::OP_ENABLE,  20, 5, 0, 0, 0, 0, 1, 0));   // slot out of range
    dir.push_back(mk(apts_pkg::OP_DISABLE, 3, 0, 0, 0, 0, 0, 1, 0));    // not queued
    dir.push_back(mk(apts_pkg::OP_ENABLE,  3, 10, 0, 0, 0, 0, 1, 1));
    dir.push_back(mk(apts_pkg::OP_ENABLE,  3, 90, 1, 0, 0, 0, 1, 0));   // duplicate
    dir.push_back(mk(apts_pkg::OP_ENABLE,  7, 10, 0, 0, 0, 0, 1, 1));
    dir.push_back(mk(apts_pkg::OP_ENABLE,  15, 255, 0, 0, 0, 0, 1, 1));
    dir.push_back(mk(apts_pkg::OP_ENABLE,  0, 0, 1, 0, 0, 0, 1, 1));
    dir.push_back(mk(apts_pkg::OP_ENABLE,  9, 200, 1, 0, 0, 0, 1, 1));
    dir.push_back(mk(apts_pkg::OP_PERIOD,  3, 0, 0, 32'h8000_0000, 0, 0, 1, 1));
    dir.push_back(mk(apts_pkg::OP_PERIOD,  7, 0, 0, 32'h7fff_ffff, 0, 0, 1, 1));
    dir.push_back(mk(apts_pkg::OP_SCHED,   0, 0, 0, 0, 1000, 16'hffff, 0, 0));
    dir.push_back(mk(apts_pkg::OP_SCHED,   0, 0, 0, 0, 32'hffff_ffff, 16'h0000, 0, 0));
    dir.push_back(mk(apts_pkg::OP_PERIOD,  SELF, 0, 0, 300, 0, 0, 1, 1));
    dir.push_back(mk(apts_pkg::OP_SCHED,   0, 0, 0, 0, 32'h8000_0000, 16'h0201, 0, 0));
    dir.push_back(mk(apts_pkg::OP_DISABLE, SELF, 0, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(apts_pkg::OP_SCHED,   0, 0, 0, 0, 32'h7fff_0000, 16'h8000, 0, 0));
    dir.push_back(mk(apts_pkg::OP_DISABLE, 31, 0, 0, 0, 0, 0, 1, 0));
    foreach (dir[j]) send_word(dir[j]);
    drain();

    // register settings: extremes, zero period, realtime level at 0
    for (n = 0; n < 5; n++) begin
      case (n)
        0: begin
          write_cfg(apts_pkg::CFG_MIN_PERIOD, 20'hfffff);
          write_cfg(apts_pkg::CFG_RT_LEVEL, 20'd0);
        end
        1: begin
          write_cfg(apts_pkg::CFG_MIN_PERIOD, 20'd0);
          write_cfg(apts_pkg::CFG_RT_LEVEL, 20'd200);
        end
        2: begin
          write_cfg(apts_pkg::CFG_MIN_PERIOD, 20'd1);
          write_cfg(apts_pkg::CFG_RT_LEVEL, 20'd255);
        end
        3: begin
          write_cfg(apts_pkg::CFG_MIN_PERIOD, 20'd37);
          write_cfg(apts_pkg::CFG_RT_LEVEL, 20'd128);
        end
        default: begin
          write_cfg(apts_pkg::CFG_MIN_PERIOD, 20'(apts_pkg::MinPeriodReset));
          write_cfg(apts_pkg::CFG_RT_LEVEL, 20'd77);
        end
      endcase
      i = 0;
      while (i < 120) begin
        b = $urandom_range(1, 12);
        repeat (b) begin
          send_word(rand_word());
          i++;
        end
        if ($urandom_range(0, 2) != 0) idle_in($urandom_range(1, 40));
        if (i > 60 && i < 73 && expected_q.size() != 0) begin
          // hold-off until all results are back
          in_valid_i <= 1'b0;
          while (expected_q.size() != 0) @(posedge clk_i);
        end
      end
      drain();
    end

    $display("Covered %0d result words, %0d schedule passes, %0d task picks,",
             n_results, n_sched, n_picks);
    $display("across five register settings including extremes.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
